[hdl/checked_command_line_parser_assert.svh]
// Assertion helpers for the command line parser.
// All checks are clocked on clk and disabled while rst is high.
`ifndef CHECKED_COMMAND_LINE_PARSER_ASSERT_SVH
`define CHECKED_COMMAND_LINE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define CCLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cclp: same-cycle check failed");

// Next-cycle implication.
`define CCLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cclp: next-cycle check failed");

`endif

[hdl/cclp_pkg.sv]
package cclp_pkg;

  localparam int FIELD_W = 16;
  localparam int ACC_W   = 17;
  localparam int CMD_LEN = 9;
  localparam int MATCH_W = 4;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [ACC_W-1:0]   ACC_LIMIT = 17'd32768;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'd32767;

  // comma counts that open the rudder and thrust fields
  localparam logic [2:0] COMMAS_RUDDER = 3'd2;
  localparam logic [2:0] COMMAS_THRUST = 3'd4;
  localparam logic [2:0] COMMAS_SAT    = 3'd7;

  typedef logic [7:0] cmd_text_t [CMD_LEN];

  // "#C,Rudder"
  localparam cmd_text_t CMD_TEXT = '{8'h23, 8'h43, 8'h2C, 8'h52, 8'h75,
                                     8'h64, 8'h64, 8'h65, 8'h72};

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } num_phase_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 4'(c - 8'h37);
    end
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

endpackage

[hdl/checked_command_line_parser.sv]
// Channel   Valid      Stall      Payload
// input     in_valid   in_stall   rx_byte
// output    out_valid  out_stall  accepted, checksum_seen, checksum_bad,
//                                 line_too_long, rudder_value, thrust_value
// config    cfg_write  -          cfg_data (paused)
//
// One word per cycle; line state is updated in the cycle the word is taken.
// A newline word registers its result, shown on the output in the next cycle.
// Only a newline word stalls, and only while an earlier result is held stalled.
// Synchronous reset clears line state as a newline does, but produces no result.
// While paused every word is taken and dropped, newlines included.
`include "checked_command_line_parser_assert.svh"

module checked_command_line_parser #(
  parameter int MAX_LINE = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 accepted,
  output logic                 checksum_seen,
  output logic                 checksum_bad,
  output logic                 line_too_long,
  output logic signed [15:0]   rudder_value,
  output logic signed [15:0]   thrust_value
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int FW    = cclp_pkg::FIELD_W;
  localparam int AW    = cclp_pkg::ACC_W;

  logic                          paused;
  logic [7:0]                    running_xor;
  logic [7:0]                    tail_bytes [4];
  logic [LEN_W-1:0]              line_length;
  logic                          overflow_flag;
  logic [cclp_pkg::MATCH_W-1:0]  match_position;
  logic                          command_found;
  logic [2:0]                    comma_count;
  cclp_pkg::num_phase_t          number_phase;
  logic                          number_negative;
  logic [AW-1:0]                 number_accumulator;
  logic [FW-1:0]                 rudder_field;
  logic [FW-1:0]                 thrust_field;
  logic [FW-1:0]                 rudder_held;
  logic [FW-1:0]                 thrust_held;

  logic in_fire;
  logic is_nl;
  logic word_fire;
  logic line_end;

  // line close
  logic       seen;
  logic [7:0] prefix;
  logic [7:0] sum;
  logic       bad;
  logic       acc_ok;

  // per-byte next values
  logic [LEN_W-1:0]             line_length_next;
  logic [cclp_pkg::MATCH_W-1:0] match_position_next;
  logic                         command_found_next;
  logic [2:0]                   comma_count_next;
  logic                         cmd_hit;

  // shared number decoder
  logic [FW-1:0]        dec_field_in;
  logic [FW-1:0]        dec_field;
  cclp_pkg::num_phase_t dec_phase;
  logic                 dec_negative;
  logic [AW-1:0]        dec_acc;
  logic [19:0]          acc_prod;
  logic [AW-1:0]        acc_sat;

  assign is_nl     = (rx_byte == cclp_pkg::CH_NL);
  assign in_stall  = out_valid && out_stall && is_nl && !paused;
  assign in_fire   = in_valid && !in_stall;
  assign word_fire = in_fire && !paused && !is_nl;
  assign line_end  = in_fire && !paused && is_nl;

  always_comb begin
    seen   = !overflow_flag && (line_length >= LEN_W'(5))
             && (tail_bytes[3] == cclp_pkg::CH_STAR);
    prefix = running_xor ^ tail_bytes[0] ^ tail_bytes[1] ^ tail_bytes[2] ^ tail_bytes[3];
    sum    = {cclp_pkg::hex_value(tail_bytes[2]), cclp_pkg::hex_value(tail_bytes[1])};
    bad    = seen && ((sum ^ prefix) != 8'd0);
    acc_ok = command_found && !overflow_flag && !bad;
  end

  always_comb begin
    line_length_next = line_length;
    if (line_length < LEN_W'(MAX_LINE)) begin
      line_length_next = line_length + LEN_W'(1);
    end

    cmd_hit = (32'(match_position) < cclp_pkg::CMD_LEN) &&
              (rx_byte == cclp_pkg::CMD_TEXT[match_position]);
    match_position_next = match_position;
    command_found_next  = command_found;
    if (!command_found) begin
      if (cmd_hit) begin
        match_position_next = match_position + cclp_pkg::MATCH_W'(1);
      end else begin
        match_position_next = (rx_byte == cclp_pkg::CH_HASH) ?
                              cclp_pkg::MATCH_W'(1) : cclp_pkg::MATCH_W'(0);
      end
      if (32'(match_position_next) >= cclp_pkg::CMD_LEN) begin
        command_found_next  = 1'b1;
        match_position_next = '0;
      end
    end

    comma_count_next = comma_count;
    if (comma_count != cclp_pkg::COMMAS_SAT) begin
      comma_count_next = comma_count + 3'd1;
    end
  end

  // atoi-style step; the accumulator holds the magnitude, capped at 32768
  always_comb begin
    dec_field_in = (comma_count == cclp_pkg::COMMAS_RUDDER) ? rudder_field : thrust_field;
    dec_field    = dec_field_in;
    dec_phase    = number_phase;
    dec_negative = number_negative;
    dec_acc      = number_accumulator;
    acc_prod     = (20'(number_accumulator) << 3) + (20'(number_accumulator) << 1)
                   + 20'(rx_byte[3:0]);
    acc_sat      = (acc_prod > 20'(cclp_pkg::ACC_LIMIT)) ? cclp_pkg::ACC_LIMIT : acc_prod[AW-1:0];
    if (number_phase == cclp_pkg::PH_BLANK && cclp_pkg::is_blank(rx_byte)) begin
      dec_phase = number_phase;
    end else if (number_phase == cclp_pkg::PH_BLANK &&
                 (rx_byte == cclp_pkg::CH_PLUS || rx_byte == cclp_pkg::CH_MINUS)) begin
      dec_negative = (rx_byte == cclp_pkg::CH_MINUS);
      dec_phase    = cclp_pkg::PH_SIGN;
    end else if (number_phase != cclp_pkg::PH_DONE && cclp_pkg::is_digit(rx_byte)) begin
      dec_phase = cclp_pkg::PH_DIGITS;
      dec_acc   = acc_sat;
      if (number_negative) begin
        dec_field = FW'(AW'(0) - acc_sat);
      end else if (acc_sat > AW'(cclp_pkg::FIELD_MAX)) begin
        dec_field = cclp_pkg::FIELD_MAX;
      end else begin
        dec_field = acc_sat[FW-1:0];
      end
    end else begin
      dec_phase = cclp_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paused <= 1'b0;
    end else if (cfg_write) begin
      paused <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || line_end) begin
      running_xor        <= '0;
      tail_bytes         <= '{default: '0};
      line_length        <= LEN_W'(1);
      overflow_flag      <= 1'b0;
      match_position     <= '0;
      command_found      <= 1'b0;
      comma_count        <= '0;
      number_phase       <= cclp_pkg::PH_BLANK;
      number_negative    <= 1'b0;
      number_accumulator <= '0;
      rudder_field       <= '0;
      thrust_field       <= '0;
    end else if (word_fire) begin
      running_xor    <= running_xor ^ rx_byte;
      tail_bytes[3]  <= tail_bytes[2];
      tail_bytes[2]  <= tail_bytes[1];
      tail_bytes[1]  <= tail_bytes[0];
      tail_bytes[0]  <= rx_byte;
      line_length    <= line_length_next;
      if (line_length_next >= LEN_W'(MAX_LINE)) begin
        overflow_flag <= 1'b1;
      end
      match_position <= match_position_next;
      command_found  <= command_found_next;
      if (rx_byte == cclp_pkg::CH_COMMA) begin
        comma_count <= comma_count_next;
        if (comma_count_next == cclp_pkg::COMMAS_RUDDER ||
            comma_count_next == cclp_pkg::COMMAS_THRUST) begin
          number_phase       <= cclp_pkg::PH_BLANK;
          number_negative    <= 1'b0;
          number_accumulator <= '0;
          if (comma_count_next == cclp_pkg::COMMAS_RUDDER) begin
            rudder_field <= '0;
          end else begin
            thrust_field <= '0;
          end
        end
      end else if (comma_count == cclp_pkg::COMMAS_RUDDER ||
                   comma_count == cclp_pkg::COMMAS_THRUST) begin
        number_phase       <= dec_phase;
        number_negative    <= dec_negative;
        number_accumulator <= dec_acc;
        if (comma_count == cclp_pkg::COMMAS_RUDDER) begin
          rudder_field <= dec_field;
        end else begin
          thrust_field <= dec_field;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rudder_held <= '0;
      thrust_held <= '0;
    end else if (line_end && acc_ok) begin
      rudder_held <= rudder_field;
      thrust_held <= thrust_field;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (line_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result word; line_end only fires when the register is free
  always_ff @(posedge clk) begin
    if (line_end) begin
      accepted      <= acc_ok;
      checksum_seen <= seen;
      checksum_bad  <= bad;
      line_too_long <= overflow_flag;
      rudder_value  <= acc_ok ? rudder_field : rudder_held;
      thrust_value  <= acc_ok ? thrust_field : thrust_held;
    end
  end

  `CCLP_ASSERT_NOW(a_acc_clean, out_valid && accepted, !line_too_long && !checksum_bad)
  `CCLP_ASSERT_NOW(a_bad_needs_seen, out_valid && checksum_bad, checksum_seen)
  `CCLP_ASSERT_NOW(a_long_no_sum, out_valid && line_too_long, !checksum_seen && !accepted)
  `CCLP_ASSERT_NOW(a_len_range, 1'b1, line_length >= LEN_W'(1) && line_length <= LEN_W'(MAX_LINE))
  `CCLP_ASSERT_NEXT(a_nl_result, line_end, out_valid && accepted == $past(acc_ok))
  `CCLP_ASSERT_NEXT(a_held_stable, !line_end, $stable(rudder_held) && $stable(thrust_held))

endmodule

[tb/sv/cclp_line_checker.sv]
`timescale 1ns / 1ps

module cclp_line_checker #(
  parameter int MAX_LINE = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               accepted,
  input  logic               checksum_seen,
  input  logic               checksum_bad,
  input  logic               line_too_long,
  input  logic signed [15:0] rudder_value,
  input  logic signed [15:0] thrust_value,
  output int                 failures,
  output int                 outstanding
);

  typedef struct packed {
    logic               acc;
    logic               seen;
    logic               bad;
    logic               too_long;
    logic signed [15:0] rudder;
    logic signed [15:0] thrust;
  } line_report_t;

  line_report_t reports_due[$];
  line_report_t got;
  line_report_t want;

  // shadow of the parser state
  logic                 paused;
  logic [7:0]           line_xor;
  logic [7:0]           last4 [4];
  int                   line_len;
  logic                 overrun;
  int                   cmd_pos;
  logic                 cmd_seen;
  logic [2:0]           commas;
  cclp_pkg::num_phase_t phase;
  logic                 minus;
  int                   magnitude;
  logic [15:0]          rudder_now;
  logic [15:0]          thrust_now;
  logic [15:0]          rudder_keep;
  logic [15:0]          thrust_keep;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // lowercase and non-hex characters read as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
    return 4'd0;
  endfunction

  function automatic logic [15:0] field_after(input logic [7:0] c, input logic [15:0] cur);
    logic is_dig;
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    if (phase == cclp_pkg::PH_BLANK && blank_char(c)) return cur;
    if (phase == cclp_pkg::PH_BLANK && (c == cclp_pkg::CH_PLUS || c == cclp_pkg::CH_MINUS)) begin
      minus = (c == cclp_pkg::CH_MINUS);
      phase = cclp_pkg::PH_SIGN;
      return cur;
    end
    if (phase != cclp_pkg::PH_DONE && is_dig) begin
      phase = cclp_pkg::PH_DIGITS;
      magnitude = magnitude * 10 + int'(c[3:0]);
      if (magnitude > 32768) magnitude = 32768;
      if (minus) return 16'(-magnitude);
      return (magnitude > 32767) ? 16'h7FFF : 16'(magnitude);
    end
    phase = cclp_pkg::PH_DONE;
    return cur;
  endfunction

  task automatic clear_line();
    line_xor = 8'h00;
    for (int i = 0; i < 4; i++) last4[i] = 8'h00;
    line_len = 1;
    overrun = 1'b0;
    cmd_pos = 0;
    cmd_seen = 1'b0;
    commas = 3'd0;
    phase = cclp_pkg::PH_BLANK;
    minus = 1'b0;
    magnitude = 0;
    rudder_now = 16'h0000;
    thrust_now = 16'h0000;
  endtask

  task automatic absorb_byte(input logic [7:0] c);
    line_report_t r;
    logic [7:0] before_star;
    logic [7:0] claimed;
    if (c == cclp_pkg::CH_NL) begin
      r.seen = !overrun && line_len >= 5 && last4[3] == cclp_pkg::CH_STAR;
      before_star = line_xor ^ last4[0] ^ last4[1] ^ last4[2] ^ last4[3];
      claimed = {nibble_of(last4[2]), nibble_of(last4[1])};
      r.bad = r.seen && (claimed != before_star);
      r.acc = cmd_seen && !overrun && !r.bad;
      r.too_long = overrun;
      if (r.acc) begin
        rudder_keep = rudder_now;
        thrust_keep = thrust_now;
      end
      r.rudder = rudder_keep;
      r.thrust = thrust_keep;
      reports_due.push_back(r);
      clear_line();
    end else begin
      line_xor ^= c;
      last4[3] = last4[2];
      last4[2] = last4[1];
      last4[1] = last4[0];
      last4[0] = c;
      if (line_len < MAX_LINE) line_len++;
      if (line_len >= MAX_LINE) overrun = 1'b1;

      if (!cmd_seen) begin
        if (cmd_pos < cclp_pkg::CMD_LEN && c == cclp_pkg::CMD_TEXT[cmd_pos]) cmd_pos++;
        else cmd_pos = (c == cclp_pkg::CH_HASH) ? 1 : 0;
        if (cmd_pos >= cclp_pkg::CMD_LEN) begin
          cmd_seen = 1'b1;
          cmd_pos = 0;
        end
      end

      if (c == cclp_pkg::CH_COMMA) begin
        if (commas != cclp_pkg::COMMAS_SAT) commas++;
        if (commas == cclp_pkg::COMMAS_RUDDER || commas == cclp_pkg::COMMAS_THRUST) begin
          phase = cclp_pkg::PH_BLANK;
          minus = 1'b0;
          magnitude = 0;
          if (commas == cclp_pkg::COMMAS_RUDDER) rudder_now = 16'h0000;
          else thrust_now = 16'h0000;
        end
      end else if (commas == cclp_pkg::COMMAS_RUDDER) begin
        rudder_now = field_after(c, rudder_now);
      end else if (commas == cclp_pkg::COMMAS_THRUST) begin
        thrust_now = field_after(c, thrust_now);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      rudder_keep = 16'h0000;
      thrust_keep = 16'h0000;
      paused = 1'b0;
      reports_due.delete();
    end else begin
      // a word taken at the same edge as a write still sees the old pause
      if (in_valid && !in_stall && !paused) absorb_byte(rx_byte);
      if (cfg_write) paused = cfg_data;
      if (out_valid && !out_stall) begin
        got.acc = accepted;
        got.seen = checksum_seen;
        got.bad = checksum_bad;
        got.too_long = line_too_long;
        got.rudder = rudder_value;
        got.thrust = thrust_value;
        if (reports_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("line_check: result word with nothing pending at %0t", $time);
        end else begin
          want = reports_due.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10)
              $display("line_check: mismatch at %0t: want acc=%0b seen=%0b bad=%0b long=%0b",
                       $time, want.acc, want.seen, want.bad, want.too_long,
                       " rudder=%0d thrust=%0d; got acc=%0b seen=%0b bad=%0b long=%0b",
                       want.rudder, want.thrust, got.acc, got.seen, got.bad, got.too_long,
                       " rudder=%0d thrust=%0d", got.rudder, got.thrust);
          end
        end
      end
    end
    outstanding = reports_due.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_LINE = 128;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_SETTLE = 3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FILL  = 8'h5A;

  typedef enum int {CK_NONE, CK_GOOD, CK_LOWER, CK_WRONG} ck_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic               cfg_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               accepted;
  logic               checksum_seen;
  logic               checksum_bad;
  logic               line_too_long;
  logic signed [15:0] rudder_value;
  logic signed [15:0] thrust_value;

  int failures;
  int outstanding;
  int cycles = 0;
  int lines_read = 0;
  int out_hold = 0;
  bit eager_send = 1'b0;
  int random_bytes = 0;
  logic [7:0] line_buf[$];

  always #5 clk = ~clk;

  checked_command_line_parser #(.MAX_LINE(MAX_LINE)) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .checksum_seen(checksum_seen),
    .checksum_bad (checksum_bad),
    .line_too_long(line_too_long),
    .rudder_value (rudder_value),
    .thrust_value (thrust_value)
  );

  cclp_line_checker #(.MAX_LINE(MAX_LINE)) line_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .checksum_seen(checksum_seen),
    .checksum_bad (checksum_bad),
    .line_too_long(line_too_long),
    .rudder_value (rudder_value),
    .thrust_value (thrust_value),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stall after each word, two long hold-offs, one stretch with none
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        lines_read = lines_read + 1;
        if (lines_read == 20 || lines_read == 55) out_hold = 400;
        else if (lines_read >= 30 && lines_read < 42) out_hold = 0;
        else out_hold = $urandom_range(0, 8);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold = out_hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic put_byte(input logic [7:0] c);
    int gap;
    gap = eager_send ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic set_paused(input logic v);
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add(input logic [7:0] c);
    line_buf.push_back(c);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_cmd();
    for (int i = 0; i < cclp_pkg::CMD_LEN; i++) line_buf.push_back(cclp_pkg::CMD_TEXT[i]);
  endtask

  task automatic add_number(input int unsigned v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'h30 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) line_buf.push_back(digs[i]);
  endtask

  // printable, never a comma
  task automatic add_junk(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(8'h21, 8'h7E));
      if (c == cclp_pkg::CH_COMMA) c = 8'h2E;
      line_buf.push_back(c);
    end
  endtask

  task automatic add_blank();
    case ($urandom_range(0, 4))
      0: add(CH_SPACE);
      1: add(CH_TAB);
      2: add(CH_VT);
      3: add(CH_FF);
      default: add(CH_CR);
    endcase
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic add_checksum(input ck_mode_t mode);
    logic [7:0] x;
    x = 8'h00;
    if (mode == CK_NONE) return;
    foreach (line_buf[i]) x ^= line_buf[i];
    if (mode == CK_WRONG) x ^= 8'(1 << $urandom_range(0, 7));
    line_buf.push_back(cclp_pkg::CH_STAR);
    line_buf.push_back(hex_char(x[7:4], mode == CK_LOWER));
    line_buf.push_back(hex_char(x[3:0], mode == CK_LOWER));
  endtask

  task automatic send_buffer();
    foreach (line_buf[i]) put_byte(line_buf[i]);
    random_bytes += line_buf.size();
    line_buf.delete();
  endtask

  task automatic ship_line();
    line_buf.push_back(cclp_pkg::CH_NL);
    send_buffer();
  endtask

  task automatic add_number_field();
    int unsigned mag;
    if ($urandom_range(0, 9) == 0) return;
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) add_blank();
    case ($urandom_range(0, 3))
      0: add(cclp_pkg::CH_PLUS);
      1: add(cclp_pkg::CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) add(8'h30);
    case ($urandom_range(0, 4))
      0: mag = $urandom_range(0, 9);
      1: mag = $urandom_range(0, 999);
      2: mag = $urandom_range(0, 32767);
      3: mag = $urandom_range(30000, 40000);
      default: mag = $urandom_range(0, 99999999);
    endcase
    add_number(mag);
    if ($urandom_range(0, 3) == 0) add_junk($urandom_range(1, 3));
  endtask

  function automatic ck_mode_t pick_checksum();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return CK_NONE;
    if (r < 14) return CK_GOOD;
    if (r < 16) return CK_LOWER;
    return CK_WRONG;
  endfunction

  task automatic finish_body();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 19);
    c = 8'($urandom_range(0, 255));
    if (c == cclp_pkg::CH_NL) c = CH_CR;
    if (r < 17) add(CH_CR);
    else if (r < 19) add(c);
  endtask

  task automatic make_command_line(input logic broken);
    int keep;
    if ($urandom_range(0, 5) == 0) add_junk($urandom_range(1, 3));
    add_cmd();
    if (broken && $urandom_range(0, 1) == 1)
      line_buf[line_buf.size() - 1 - $urandom_range(0, 8)] = 8'($urandom_range(8'h21, 8'h7E));
    keep = broken ? $urandom_range(0, 3) : 3;
    if (keep > 0) begin
      add(cclp_pkg::CH_COMMA);
      add_number_field();
    end
    if (keep > 1) begin
      add(cclp_pkg::CH_COMMA);
      add_junk($urandom_range(0, 4));
    end
    if (keep > 2) begin
      add(cclp_pkg::CH_COMMA);
      add_number_field();
    end
    if (!broken && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        add(cclp_pkg::CH_COMMA);
        add_number_field();
      end
    end
    add_checksum(pick_checksum());
    finish_body();
    ship_line();
  endtask

  // body_len counts every byte ahead of the newline
  task automatic make_long_line(input int body_len, input logic with_cmd, input ck_mode_t ck);
    int room;
    room = body_len - 1 - ((ck == CK_NONE) ? 0 : 3);
    if (with_cmd) begin
      add_cmd();
      add_str(",11,q,22");
    end
    while (line_buf.size() < room) add(CH_FILL);
    add_checksum(ck);
    add(CH_CR);
    ship_line();
  endtask

  // bytes sent here are dropped by the block and not counted
  task automatic paused_stretch(input int n);
    logic [7:0] c;
    wait_drained();
    set_paused(1'b1);
    for (int i = 0; i < n; i++) begin
      c = (i % 6 == 5) ? cclp_pkg::CH_NL : 8'($urandom_range(0, 255));
      put_byte(c);
    end
    wait_drained();
    set_paused(1'b0);
  endtask

  initial begin
    int pick;
    int line_no;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // plain command, with no, good, wrong and lowercase checksums
    add_cmd(); add_str(",100,x,-200"); add(CH_CR); ship_line();
    add_cmd(); add_str(",+42,,  7"); add_checksum(CK_GOOD); add(CH_CR); ship_line();
    add_cmd(); add_str(",5,y,6"); add_checksum(CK_WRONG); add(CH_CR); ship_line();
    add_cmd(); add_str(",1,a,2"); add_checksum(CK_LOWER); add(CH_CR); ship_line();
    // saturation at both ends
    add_cmd(); add_str(",99999999,q,-99999999"); add(CH_CR); ship_line();
    add_cmd(); add_str(",32768,q,-32768"); add(CH_CR); ship_line();
    add_cmd(); add_str(",-32767,q,32767"); add(CH_CR); ship_line();
    // whitespace before sign, junk after digits
    add_cmd(); add(cclp_pkg::CH_COMMA); add(CH_SPACE); add(CH_TAB); add_str("+12abc,q,");
    add(CH_VT); add(CH_FF); add_str("-7 9"); add(CH_CR); ship_line();
    // missing fields read as zero
    add_cmd(); add(CH_CR); ship_line();
    add_cmd(); add_str(",77"); ship_line();
    add_cmd(); add_str(",- 5,q,--5"); add(CH_CR); ship_line();
    // not the command
    add_str("$GP,1,2,3"); add_checksum(CK_GOOD); add(CH_CR); ship_line();
    ship_line();
    add_str("*00"); add(CH_CR); ship_line();
    add_str("*00"); ship_line();
    // matcher restarts on a second hash, then extra fields and non-printable bytes
    add_str("##C,Rudder,3,q,4"); add(CH_CR); ship_line();
    add_str("#C,Rud#C,Rudder,9,q,8"); add(CH_CR); ship_line();
    add_cmd(); add_str(",1,2,3,4,5,6,7,8,9"); add_checksum(CK_GOOD); add(CH_CR); ship_line();
    add_cmd(); add(cclp_pkg::CH_COMMA); add(8'h00); add_str("3,"); add(8'hFF);
    add(cclp_pkg::CH_COMMA);
    add(8'h80); add_str("5"); add(CH_CR); ship_line();
    // longest body that still fits, then one byte over, then well over
    make_long_line(MAX_LINE - 2, 1'b1, CK_NONE);
    make_long_line(MAX_LINE - 2, 1'b1, CK_GOOD);
    make_long_line(MAX_LINE - 1, 1'b1, CK_GOOD);
    make_long_line(MAX_LINE + 5, 1'b1, CK_NONE);

    // a line split by a pause keeps its state
    wait_drained();
    set_paused(1'b0);
    add_cmd(); add_str(",1"); send_buffer();
    paused_stretch(40);
    add_str("2,q,3"); add(CH_CR); ship_line();

    line_no = 0;
    while (random_bytes < 1650) begin
      eager_send = (line_no % 10) < 2;
      pick = $urandom_range(0, 99);
      if (pick < 64) begin
        make_command_line(1'b0);
      end else if (pick < 79) begin
        make_command_line(1'b1);
      end else if (pick < 96) begin
        repeat ($urandom_range(0, 20)) add(8'($urandom_range(0, 255)));
        ship_line();
      end else begin
        make_long_line($urandom_range(MAX_LINE - 8, MAX_LINE + 22),
                       1'($urandom_range(0, 1)), pick_checksum());
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
      if (line_no == 10) paused_stretch(60);
      line_no++;
    end
    eager_send = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/cclp_pkg.sv
hdl/checked_command_line_parser.sv
tb/sv/cclp_line_checker.sv
tb/sv/tb_top.sv
